[rtl/tty_input_line_discipline_defines.svh]
// Assertion helpers for the console input line discipline.
`ifndef TTY_INPUT_LINE_DISCIPLINE_DEFINES_SVH
`define TTY_INPUT_LINE_DISCIPLINE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TTYLD_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ttyld check failed");

// Next-cycle implication.
`define TTYLD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ttyld check failed");

`endif

[rtl/ttyld_pkg.sv]
package ttyld_pkg;

    localparam int CHUNK_BYTES = 128;
    localparam int CNT_W       = 16;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_CTRL_D = 8'h04;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_CTRL_P = 8'h10;
    localparam logic [7:0] CH_ESC    = 8'h1b;
    localparam logic [7:0] CH_LBRACK = 8'h5b;
    localparam logic [7:0] CH_UPPER_O = 8'h4f;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TILDE  = 8'h7e;

    typedef enum logic [1:0] {
        REG_CONSOLE_MODE  = 2'd0,
        REG_CRLF_COLLAPSE = 2'd1,
        REG_READ_LENGTH   = 2'd2
    } reg_index_t;

    typedef enum logic [2:0] {
        END_NONE      = 3'd0,
        END_NEWLINE   = 3'd1,
        END_LENGTH    = 3'd2,
        END_EOF_EMPTY = 3'd3,
        END_EOF_DATA  = 3'd4
    } end_code_t;

    typedef enum logic [1:0] {
        ESC_IDLE  = 2'd0,
        ESC_FIRST = 2'd1,
        ESC_CSI   = 2'd2
    } esc_phase_t;

    typedef struct packed {
        logic             console_mode;
        logic             crlf_collapse;
        logic [CNT_W-1:0] read_length;
    } cfg_t;

    typedef struct packed {
        esc_phase_t       escape_phase;
        logic             after_cr;
        logic [CNT_W-1:0] read_count;
    } ld_state_t;

    typedef struct packed {
        logic      dump_request;
        end_code_t end_code;
        logic      echo_valid;
        logic [7:0] delivered_byte;
        logic      deliver_valid;
    } result_t;

endpackage

[rtl/tty_input_line_discipline.sv]
// An accepted request's result is registered and appears on m_tdata in the next cycle.
// Throughput: 1 request per cycle; the single output register is the only
//   stage, and a new request is taken whenever it is empty or being drained.
// Reset (rst_n low, asynchronous): TTY mode, CR/LF collapse on, read length 1,
//   line state cleared, output register empty.
module tty_input_line_discipline (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] action (1 = flush)
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [0] deliver_valid, [8:1] delivered_byte,
                                   // [9] echo_valid, [12:10] end_code,
                                   // [13] dump_request, [15:14] zero
);

    ttyld_pkg::cfg_t      cfg_reg;
    ttyld_pkg::ld_state_t state_reg;
    ttyld_pkg::ld_state_t state_next;
    ttyld_pkg::result_t   res_next;
    ttyld_pkg::result_t   res_reg;
    logic                 out_valid_reg;
    logic                 accept;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    ttyld_step u_step (
        .cfg     (cfg_reg),
        .st      (state_reg),
        .action  (s_tuser),
        .rx_byte (s_tdata),
        .st_next (state_next),
        .res     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.console_mode  <= 1'b0;
            cfg_reg.crlf_collapse <= 1'b1;
            cfg_reg.read_length   <= ttyld_pkg::CNT_W'(1);
            state_reg             <= '0;
            out_valid_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    ttyld_pkg::REG_CONSOLE_MODE:
                    begin
                        cfg_reg.console_mode <= cfg_data[0];
                        state_reg            <= '0;
                    end
                    ttyld_pkg::REG_CRLF_COLLAPSE:
                    begin
                        cfg_reg.crlf_collapse <= cfg_data[0];
                    end
                    ttyld_pkg::REG_READ_LENGTH:
                    begin
                        cfg_reg.read_length <= cfg_data;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (accept)
                state_reg <= state_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, res_reg};

endmodule

[rtl/ttyld_step.sv]
module ttyld_step (
    input  ttyld_pkg::cfg_t      cfg,
    input  ttyld_pkg::ld_state_t st,
    input  logic                 action,
    input  logic [7:0]           rx_byte,
    output ttyld_pkg::ld_state_t st_next,
    output ttyld_pkg::result_t   res
);

    localparam logic [ttyld_pkg::CNT_W-1:0] CHUNK_LIM =
        ttyld_pkg::CNT_W'(ttyld_pkg::CHUNK_BYTES);

    logic [ttyld_pkg::CNT_W-1:0] cnt_inc;
    logic [ttyld_pkg::CNT_W-1:0] lim_raw;
    logic [ttyld_pkg::CNT_W-1:0] lim_tty;

    assign cnt_inc = st.read_count + 1'b1;

    // zero length behaves as one
    always_comb
    begin
        lim_raw = (cfg.read_length > CHUNK_LIM) ? CHUNK_LIM : cfg.read_length;
        if (lim_raw == '0)
            lim_raw = ttyld_pkg::CNT_W'(1);
        lim_tty = (cfg.read_length == '0) ? ttyld_pkg::CNT_W'(1) : cfg.read_length;
    end

    always_comb
    begin
        logic [7:0] c;
        logic       keep;
        logic       echo;

        c       = rx_byte;
        keep    = 1'b1;
        echo    = 1'b0;
        st_next = st;
        res     = '0;

        if (action)
        begin
            st_next = '0;
        end
        else if (cfg.console_mode)
        begin
            res.deliver_valid  = 1'b1;
            res.delivered_byte = c;
            st_next.read_count = cnt_inc;
            if (cnt_inc >= lim_raw)
            begin
                res.end_code       = ttyld_pkg::END_LENGTH;
                st_next.read_count = '0;
            end
        end
        else if (c == ttyld_pkg::CH_CTRL_P)
        begin
            res.dump_request = 1'b1;
        end
        else if (c != ttyld_pkg::CH_NUL)
        begin
            if (c == ttyld_pkg::CH_CR)
            begin
                c                = ttyld_pkg::CH_LF;
                st_next.after_cr = cfg.crlf_collapse;
            end
            else if (st.after_cr && c == ttyld_pkg::CH_LF && cfg.crlf_collapse)
            begin
                st_next.after_cr = 1'b0;
                keep             = 1'b0;
            end
            else
            begin
                st_next.after_cr = 1'b0;
            end

            if (keep)
            begin
                echo = (c >= ttyld_pkg::CH_SPACE && c <= ttyld_pkg::CH_TILDE) ||
                       c == ttyld_pkg::CH_LF;
                if (c == ttyld_pkg::CH_ESC)
                begin
                    st_next.escape_phase = ttyld_pkg::ESC_FIRST;
                    echo = 1'b0;
                end
                else if (st.escape_phase != ttyld_pkg::ESC_IDLE)
                begin
                    echo = 1'b0;
                    if (st.escape_phase == ttyld_pkg::ESC_FIRST &&
                        (c == ttyld_pkg::CH_LBRACK || c == ttyld_pkg::CH_UPPER_O))
                        st_next.escape_phase = ttyld_pkg::ESC_CSI;
                    else
                        st_next.escape_phase = ttyld_pkg::ESC_IDLE;
                end

                if (c == ttyld_pkg::CH_CTRL_D)
                begin
                    res.end_code = (st.read_count != '0) ? ttyld_pkg::END_EOF_DATA
                                                         : ttyld_pkg::END_EOF_EMPTY;
                    st_next.read_count = '0;
                end
                else
                begin
                    res.deliver_valid  = 1'b1;
                    res.delivered_byte = c;
                    res.echo_valid     = echo;
                    st_next.read_count = cnt_inc;
                    // newline wins over length
                    if (c == ttyld_pkg::CH_LF)
                    begin
                        res.end_code       = ttyld_pkg::END_NEWLINE;
                        st_next.read_count = '0;
                    end
                    else if (cnt_inc >= lim_tty)
                    begin
                        res.end_code       = ttyld_pkg::END_LENGTH;
                        st_next.read_count = '0;
                    end
                end
            end
        end
    end

endmodule

[rtl/ttyld_checker.sv]
`include "tty_input_line_discipline_defines.svh"

module ttyld_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // a stalled result holds
    `TTYLD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // every accepted request shows a result in the next cycle
    `TTYLD_ASSERT_NEXT(a_one_cycle, s_tvalid && s_tready, m_tvalid)

    // undelivered byte reads as zero, no echo
    `TTYLD_ASSERT_IMPL(a_undelivered_zero, m_tvalid && !m_tdata[0],
        m_tdata[8:1] == 8'h00 && !m_tdata[9])

    // dump request carries nothing else
    `TTYLD_ASSERT_IMPL(a_dump_alone, m_tvalid && m_tdata[13],
        !m_tdata[0] && m_tdata[12:10] == 3'd0)

    // end code stays within its defined values
    `TTYLD_ASSERT_IMPL(a_end_code_range, m_tvalid,
        !(m_tdata[12] && (m_tdata[11] || m_tdata[10])))

endmodule

bind tty_input_line_discipline ttyld_checker u_ttyld_checker (.*);

[tb/tb_tty_input_line_discipline.sv]
module tb_tty_input_line_discipline;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_OFF_CYCLES = 200;

    class line_scoreboard;
        // register copies
        bit          raw_mode;
        bit          collapse;
        logic [15:0] length;
        // line state
        ttyld_pkg::esc_phase_t esc;
        bit          cr_seen;
        logic [15:0] count;

        ttyld_pkg::result_t byte_outcomes[$];
        int          requests;
        int          flushes;
        int          outcomes;
        int          errors;

        function new();
            raw_mode = 0;
            collapse = 1;
            length = 16'd1;
            clear_line();
            requests = 0;
            flushes = 0;
            outcomes = 0;
            errors = 0;
        endfunction

        function void clear_line();
            esc = ttyld_pkg::ESC_IDLE;
            cr_seen = 0;
            count = '0;
        endfunction

        function void set_reg(ttyld_pkg::reg_index_t idx, logic [15:0] val);
            case (idx)
                ttyld_pkg::REG_CONSOLE_MODE:
                begin
                    raw_mode = val[0];
                    clear_line();
                end
                ttyld_pkg::REG_CRLF_COLLAPSE: collapse = val[0];
                ttyld_pkg::REG_READ_LENGTH:   length = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return byte_outcomes.size();
        endfunction

        // work out the outcome of one accepted request
        function void take_request(logic flush, logic [7:0] rx);
            ttyld_pkg::result_t r;
            logic [7:0]  c;
            logic [15:0] cap;
            bit          keep;
            bit          echo;
            r = '0;
            c = rx;
            requests++;
            if (flush)
            begin
                flushes++;
                clear_line();
            end
            else if (raw_mode)
            begin
                cap = (length > ttyld_pkg::CHUNK_BYTES) ? 16'(ttyld_pkg::CHUNK_BYTES) : length;
                if (cap == 0)
                    cap = 16'd1;
                r.deliver_valid = 1;
                r.delivered_byte = c;
                count = count + 16'd1;
                if (count >= cap)
                begin
                    r.end_code = ttyld_pkg::END_LENGTH;
                    count = '0;
                end
            end
            else if (c == ttyld_pkg::CH_CTRL_P)
                r.dump_request = 1;
            else if (c != ttyld_pkg::CH_NUL)
            begin
                keep = 1;
                if (c == ttyld_pkg::CH_CR)
                begin
                    c = ttyld_pkg::CH_LF;
                    cr_seen = collapse;
                end
                else if (cr_seen && c == ttyld_pkg::CH_LF && collapse)
                begin
                    cr_seen = 0;
                    keep = 0;
                end
                else
                    cr_seen = 0;
                if (keep)
                begin
                    echo = (c >= ttyld_pkg::CH_SPACE && c <= ttyld_pkg::CH_TILDE)
                           || c == ttyld_pkg::CH_LF;
                    if (c == ttyld_pkg::CH_ESC)
                    begin
                        esc = ttyld_pkg::ESC_FIRST;
                        echo = 0;
                    end
                    else if (esc != ttyld_pkg::ESC_IDLE)
                    begin
                        echo = 0;
                        esc = (esc == ttyld_pkg::ESC_FIRST
                               && (c == ttyld_pkg::CH_LBRACK || c == ttyld_pkg::CH_UPPER_O))
                              ? ttyld_pkg::ESC_CSI : ttyld_pkg::ESC_IDLE;
                    end
                    if (c == ttyld_pkg::CH_CTRL_D)
                    begin
                        r.end_code = (count != 0) ? ttyld_pkg::END_EOF_DATA
                                                  : ttyld_pkg::END_EOF_EMPTY;
                        count = '0;
                    end
                    else
                    begin
                        r.deliver_valid = 1;
                        r.delivered_byte = c;
                        r.echo_valid = echo;
                        count = count + 16'd1;
                        if (c == ttyld_pkg::CH_LF)
                        begin
                            r.end_code = ttyld_pkg::END_NEWLINE;
                            count = '0;
                        end
                        else if (count >= ((length == 0) ? 16'd1 : length))
                        begin
                            r.end_code = ttyld_pkg::END_LENGTH;
                            count = '0;
                        end
                    end
                end
            end
            byte_outcomes.push_back(r);
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 10)
                $display("%t MISMATCH: %s", $time, msg);
        endfunction

        function void check_outcome(logic [15:0] data);
            ttyld_pkg::result_t got;
            ttyld_pkg::result_t want;
            got = data[13:0];
            outcomes++;
            if (byte_outcomes.size() == 0)
            begin
                report($sformatf("unexpected result %h", data));
                return;
            end
            want = byte_outcomes.pop_front();
            if (got.deliver_valid !== want.deliver_valid
                || got.delivered_byte !== want.delivered_byte
                || got.echo_valid !== want.echo_valid
                || got.end_code !== want.end_code
                || got.dump_request !== want.dump_request)
                report($sformatf({"expected dv=%0d byte=%h echo=%0d end=%0d dump=%0d,",
                                  " got dv=%0d byte=%h echo=%0d end=%0d dump=%0d"},
                                 want.deliver_valid, want.delivered_byte, want.echo_valid,
                                 want.end_code, want.dump_request,
                                 got.deliver_valid, got.delivered_byte, got.echo_valid,
                                 got.end_code, got.dump_request));
        endfunction

        function void close_out();
            if (byte_outcomes.size() != 0)
                report($sformatf("%0d results never arrived", byte_outcomes.size()));
        endfunction
    endclass

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    line_scoreboard sb = new();
    bit hold_off_req = 0;
    int burst_left = 0;
    int settings_run = 0;

    tty_input_line_discipline dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_outcome(m_tdata);
    end

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int r;
        forever
        begin
            if (hold_off_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 0;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                begin
                    m_tready <= 1'b1;
                    repeat ($urandom_range(1, 20)) @(posedge clk);
                end
                else if (r < 95)
                begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge clk);
                end
                else
                begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(10, 40)) @(posedge clk);
                end
            end
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    task automatic send_request(logic flush, logic [7:0] rx);
        int r;
        int gap;
        s_tvalid <= 1'b1;
        s_tuser <= flush;
        s_tdata <= rx;
        do
            @(posedge clk);
        while (!s_tready);
        sb.take_request(flush, rx);
        r = $urandom_range(0, 99);
        if (burst_left > 0)
        begin
            burst_left--;
            gap = 0;
        end
        else if (r < 65)
            gap = 0;
        else if (r < 93)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 30);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_byte(logic [7:0] rx);
        send_request(1'b0, rx);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(ttyld_pkg::reg_index_t idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge clk);
    endtask

    function automatic logic [7:0] printable();
        return 8'($urandom_range(ttyld_pkg::CH_TILDE, ttyld_pkg::CH_SPACE));
    endfunction

    // mostly line-shaped traffic with escapes, EOFs and some noise
    task automatic send_tty_burst();
        int r;
        int s;
        r = $urandom_range(0, 99);
        if (r < 50)
            send_byte(printable());
        else if (r < 58)
            send_byte(ttyld_pkg::CH_CR);
        else if (r < 64)
            send_byte(ttyld_pkg::CH_LF);
        else if (r < 68)
        begin
            send_byte(ttyld_pkg::CH_CR);
            send_byte(ttyld_pkg::CH_LF);
        end
        else if (r < 74)
        begin
            send_byte(ttyld_pkg::CH_ESC);
            s = $urandom_range(0, 2);
            send_byte(s == 0 ? ttyld_pkg::CH_LBRACK
                             : (s == 1 ? ttyld_pkg::CH_UPPER_O : printable()));
            send_byte(printable());
        end
        else if (r < 78)
            send_byte(ttyld_pkg::CH_CTRL_D);
        else if (r < 81)
            send_byte(ttyld_pkg::CH_CTRL_P);
        else if (r < 83)
            send_byte(ttyld_pkg::CH_NUL);
        else if (r < 86)
            send_request(1'b1, 8'($urandom_range(0, 255)));
        else if (r < 88)
        begin
            send_byte(ttyld_pkg::CH_ESC);
            send_byte(ttyld_pkg::CH_CTRL_D);
        end
        else
            send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic run_setting(bit raw, bit collapse, logic [15:0] len, int n);
        int start;
        wait_idle();
        write_reg(ttyld_pkg::REG_CONSOLE_MODE, {15'd0, raw});
        write_reg(ttyld_pkg::REG_CRLF_COLLAPSE, {15'd0, collapse});
        write_reg(ttyld_pkg::REG_READ_LENGTH, len);
        settings_run++;
        start = sb.requests;
        while (sb.requests - start < n)
        begin
            if (!raw)
                send_tty_burst();
            else if ($urandom_range(0, 99) < 3)
                send_request(1'b1, 8'($urandom_range(0, 255)));
            else
                send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset length of one ends the read at once
        send_byte("a");
        wait_idle();
        write_reg(ttyld_pkg::REG_READ_LENGTH, 16'd6);
        send_byte(ttyld_pkg::CH_NUL);
        send_byte(ttyld_pkg::CH_CTRL_P);
        send_byte(ttyld_pkg::CH_CTRL_D);
        send_byte(ttyld_pkg::CH_SPACE);
        send_byte(ttyld_pkg::CH_TILDE);
        send_byte(ttyld_pkg::CH_CTRL_D);
        send_byte(ttyld_pkg::CH_CR);
        send_byte(ttyld_pkg::CH_LF);
        send_byte(ttyld_pkg::CH_LF);
        send_byte(8'h7f);
        send_byte(8'hff);
        send_byte(ttyld_pkg::CH_ESC);
        send_byte(ttyld_pkg::CH_LBRACK);
        send_byte("A");
        send_byte(ttyld_pkg::CH_ESC);
        send_byte(ttyld_pkg::CH_UPPER_O);
        send_byte(ttyld_pkg::CH_ESC);
        send_byte("x");
        send_byte("y");
        send_byte(ttyld_pkg::CH_CR);
        send_request(1'b1, 8'h00);
        send_byte(ttyld_pkg::CH_LF);
        send_byte(ttyld_pkg::CH_ESC);
        send_byte(ttyld_pkg::CH_CTRL_D);

        run_setting(1'b0, 1'b1, 16'd1, 130);
        run_setting(1'b0, 1'b1, 16'd0, 130);
        run_setting(1'b0, 1'b0, 16'd8, 130);
        // long receiver hold-off while requests keep coming
        hold_off_req = 1;
        burst_left = 40;
        run_setting(1'b0, 1'b1, 16'd65535, 130);
        run_setting(1'b1, 1'b0, 16'd0, 130);
        run_setting(1'b1, 1'b1, 16'd3, 130);
        run_setting(1'b1, 1'b0, 16'd200, 130);
        run_setting(1'b0, 1'b1, 16'd40, 130);
        run_setting(1'b1, 1'b1, 16'd128, 130);
        run_setting(1'b0, 1'b0, 16'd65535, 130);
        run_setting(1'b0, 1'b1, 16'd127, 130);

        wait_idle();
        repeat (5) @(posedge clk);
        sb.close_out();
        $display("run covered %0d requests (%0d flushes) over %0d register settings,",
                 sb.requests, sb.flushes, settings_run + 1);
        $display("%0d results checked, %0d mismatches", sb.outcomes, sb.errors);
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/ttyld_pkg.sv
rtl/ttyld_step.sv
rtl/tty_input_line_discipline.sv
rtl/ttyld_checker.sv
tb/tb_tty_input_line_discipline.sv
